@@ design/nsc_pkg.sv @@
// ----------------------------------------------------------------------------
// NMEA sentence checker package
// Transaction types, character constants and the hex digit decoder.
// ----------------------------------------------------------------------------
package nsc_pkg;

  // Width of the tag register and of the byte window that precedes a byte.
  localparam int unsigned TagWidth    = 48;
  localparam int unsigned WindowWidth = TagWidth - 8;

  // Tag register value after reset: "$GPGGA".
  localparam logic [TagWidth-1:0] TAG_RESET = 48'h2447_5047_4741;

  // Characters with a meaning of their own.
  localparam logic [7:0] CHAR_STAR   = 8'h2A;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_NINE   = 8'h39;
  localparam logic [7:0] CHAR_UPPR_A = 8'h41;
  localparam logic [7:0] CHAR_UPPR_F = 8'h46;
  localparam logic [7:0] CHAR_LOWR_A = 8'h61;
  localparam logic [7:0] CHAR_LOWR_F = 8'h66;

  // Number of checksum digits that follow the star.
  localparam logic [1:0] SUM_DIGITS = 2'd2;

  // One input transaction.
  typedef struct packed {
    logic [7:0] line_byte;
    logic       end_of_line;
  } in_item_t;

  // One result transaction.
  typedef struct packed {
    logic       sentence_ok;
    logic       tag_found;
    logic       sum_match;
    logic       format_error;
    logic [7:0] computed_sum;
    logic [7:0] received_sum;
  } out_item_t;

  // Control handed from the input stage to the line tracker.
  typedef struct packed {
    logic       step;
    logic       end_of_line;
    logic [7:0] line_byte;
  } step_t;

  // Hex digit decode: bit 4 is set when the byte is a hex digit, bits 3:0
  // hold its value (zero when it is not one).
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [7:0] diff;
    diff = 8'd0;
    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      diff = c - CHAR_ZERO;
      return {1'b1, diff[3:0]};
    end else if (c >= CHAR_UPPR_A && c <= CHAR_UPPR_F) begin
      diff = c - CHAR_UPPR_A + 8'd10;
      return {1'b1, diff[3:0]};
    end else if (c >= CHAR_LOWR_A && c <= CHAR_LOWR_F) begin
      diff = c - CHAR_LOWR_A + 8'd10;
      return {1'b1, diff[3:0]};
    end
    return 5'd0;
  endfunction

endpackage

@@ design/nmea_sentence_checker_top.sv @@
// ----------------------------------------------------------------------------
// NMEA sentence checker
// Checks NMEA-0183 sentences byte by byte: XOR sum, hex checksum, tag search.
// ----------------------------------------------------------------------------
//
//  Channel  Ports                          Direction  Transaction
//  -------  -----------------------------  ---------  ---------------------------
//  in       in_valid, in_stall, in_data    input      one line byte, end flag
//  out      out_valid, out_stall, out_data output     one verdict per line
//  cfg      cfg_wr_en, cfg_wr_data         input      write of the tag register
//
//  One byte is accepted every cycle unless the input stalls; each byte waits in the
//  input register until the line tracker consumes it, and the verdict is registered
//  in the result register when the tracker consumes the line's end-of-line byte.
//  The input stalls only while an end-of-line byte waits in the input
//  register and the result register still holds an untaken verdict.
//  Synchronous reset clears the line state and sets the tag to "$GPGGA".
//
module nmea_sentence_checker_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [nsc_pkg::TagWidth-1:0] cfg_wr_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  nsc_pkg::in_item_t            in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output nsc_pkg::out_item_t           out_data
);
  import nsc_pkg::*;

  logic [TagWidth-1:0] tag_r;
  logic                s1_valid_r;
  in_item_t            s1_data_r;
  logic                out_valid_r;
  out_item_t           out_data_r;

  logic                out_free;
  logic                s1_consume;
  logic                in_accept;
  step_t               step;
  out_item_t           verdict;

  // Handshake decisions.
  always_comb begin
    out_free         = ~out_valid_r | ~out_stall;
    s1_consume       = s1_valid_r & (~s1_data_r.end_of_line | out_free);
    in_stall         = s1_valid_r & ~s1_consume;
    in_accept        = in_valid & ~in_stall;
    step.step        = s1_consume;
    step.end_of_line = s1_data_r.end_of_line;
    step.line_byte   = s1_data_r.line_byte;
  end

  nsc_line_tracker u_tracker (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_in     (step),
    .tag_pattern (tag_r),
    .verdict     (verdict)
  );

  // Control registers: tag, input stage valid and result valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r       <= TAG_RESET;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        tag_r <= cfg_wr_data;
      end
      if (in_accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_consume) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_consume && s1_data_r.end_of_line) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_data_r <= in_data;
    end
    if (s1_consume && s1_data_r.end_of_line) begin
      out_data_r <= verdict;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A byte that ends no line never waits in the input register.
  a_mid_line_flows: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_data_r.end_of_line) |-> s1_consume)
    else $error("mid-line byte held in input register");

  // Stalling the input only happens behind a held verdict.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_data_r.end_of_line && out_valid_r && out_stall))
    else $error("input stalled without a held verdict");

  // A passing verdict needs both the tag and the checksum.
  a_ok_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.sentence_ok) |->
      (out_data_r.tag_found && out_data_r.sum_match && !out_data_r.format_error))
    else $error("sentence_ok set without tag and checksum");

endmodule

@@ design/nsc_line_tracker.sv @@
// ----------------------------------------------------------------------------
// NMEA sentence checker line tracker
// Holds the per-line state (sum, star, checksum digits, tag window) and
// forms the verdict for the byte that ends a line.
// ----------------------------------------------------------------------------
module nsc_line_tracker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  nsc_pkg::step_t                   step_in,
  input  logic [nsc_pkg::TagWidth-1:0]     tag_pattern,
  output nsc_pkg::out_item_t               verdict
);
  import nsc_pkg::*;

  logic [7:0]             xor_accum_r, xor_accum_nxt;
  logic                   first_done_r, first_done_nxt;
  logic                   star_r, star_nxt;
  logic [1:0]             dcount_r, dcount_nxt;
  logic [7:0]             recv_r, recv_nxt;
  logic                   bad_r, bad_nxt;
  logic [WindowWidth-1:0] window_r, window_nxt;
  logic                   hit_r, hit_nxt;

  // Values after this byte, before the end-of-line clear.
  logic [7:0]          xor_upd;
  logic                first_upd, star_upd, bad_upd, hit_upd;
  logic [1:0]          dcount_upd;
  logic [7:0]          recv_upd;
  logic [TagWidth-1:0] full_window;
  logic [4:0]          hex;
  logic                ferr, match;

  // Update the line state with one byte.
  always_comb begin
    full_window = {window_r, step_in.line_byte};
    hit_upd     = hit_r | (full_window == tag_pattern);
    hex         = hex_decode(step_in.line_byte);
    xor_upd     = xor_accum_r;
    first_upd   = first_done_r;
    star_upd    = star_r;
    dcount_upd  = dcount_r;
    recv_upd    = recv_r;
    bad_upd     = bad_r;
    priority if (!first_done_r) begin
      first_upd = 1'b1;
    end else if (!star_r) begin
      if (step_in.line_byte == CHAR_STAR) begin
        star_upd = 1'b1;
      end else begin
        xor_upd = xor_accum_r ^ step_in.line_byte;
      end
    end else if (dcount_r < SUM_DIGITS) begin
      bad_upd    = bad_r | ~hex[4];
      recv_upd   = {recv_r[3:0], hex[3:0]};
      dcount_upd = dcount_r + 2'd1;
    end else begin
      // Bytes after the checksum digits only pass through the tag window.
      bad_upd    = bad_r;
    end
  end

  // Verdict from the updated state.
  always_comb begin
    ferr                 = ~star_upd | (dcount_upd < SUM_DIGITS) | bad_upd;
    match                = ~ferr & (xor_upd == recv_upd);
    verdict.sentence_ok  = hit_upd & match;
    verdict.tag_found    = hit_upd;
    verdict.sum_match    = match;
    verdict.format_error = ferr;
    verdict.computed_sum = xor_upd;
    verdict.received_sum = recv_upd;
  end

  // Next state: the end of a line clears everything.
  always_comb begin
    xor_accum_nxt  = xor_accum_r;
    first_done_nxt = first_done_r;
    star_nxt       = star_r;
    dcount_nxt     = dcount_r;
    recv_nxt       = recv_r;
    bad_nxt        = bad_r;
    window_nxt     = window_r;
    hit_nxt        = hit_r;
    if (step_in.step) begin
      if (step_in.end_of_line) begin
        xor_accum_nxt  = 8'd0;
        first_done_nxt = 1'b0;
        star_nxt       = 1'b0;
        dcount_nxt     = 2'd0;
        recv_nxt       = 8'd0;
        bad_nxt        = 1'b0;
        window_nxt     = '0;
        hit_nxt        = 1'b0;
      end else begin
        xor_accum_nxt  = xor_upd;
        first_done_nxt = first_upd;
        star_nxt       = star_upd;
        dcount_nxt     = dcount_upd;
        recv_nxt       = recv_upd;
        bad_nxt        = bad_upd;
        window_nxt     = full_window[WindowWidth-1:0];
        hit_nxt        = hit_upd;
      end
    end
  end

  // Line state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xor_accum_r  <= 8'd0;
      first_done_r <= 1'b0;
      star_r       <= 1'b0;
      dcount_r     <= 2'd0;
      recv_r       <= 8'd0;
      bad_r        <= 1'b0;
      window_r     <= '0;
      hit_r        <= 1'b0;
    end else begin
      xor_accum_r  <= xor_accum_nxt;
      first_done_r <= first_done_nxt;
      star_r       <= star_nxt;
      dcount_r     <= dcount_nxt;
      recv_r       <= recv_nxt;
      bad_r        <= bad_nxt;
      window_r     <= window_nxt;
      hit_r        <= hit_nxt;
    end
  end

  // The digit counter stops at the number of checksum digits.
  a_dcount_bound: assert property (@(posedge clk) disable iff (!rst_n)
    dcount_r <= SUM_DIGITS)
    else $error("checksum digit counter overran");

  // A star is only recognised after the first byte.
  a_star_after_first: assert property (@(posedge clk) disable iff (!rst_n)
    star_r |-> first_done_r)
    else $error("star seen before first byte");

  // Digits are only collected once the star has been seen.
  a_digits_after_star: assert property (@(posedge clk) disable iff (!rst_n)
    (dcount_r != 2'd0) |-> star_r)
    else $error("checksum digit taken without a star");

endmodule

@@ tb/nsc_verdict_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// NMEA sentence verdict checker
// Watches the byte, verdict and tag register ports of the sentence checker.
// It keeps its own copy of the tag and of the line state, works out the
// verdict due for each end-of-line byte and compares every verdict that
// leaves the block against the oldest one still owed.
// ----------------------------------------------------------------------------
module nsc_verdict_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [nsc_pkg::TagWidth-1:0] cfg_wr_data,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  nsc_pkg::in_item_t            in_data,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  nsc_pkg::out_item_t           out_data,
  output int                           fail_count,
  output int                           verdicts_pending
);
  import nsc_pkg::*;

  // Shadow of the tag register and of the per-line state.
  logic [TagWidth-1:0]    tag_copy;
  logic [WindowWidth-1:0] prev_bytes;
  logic [7:0]             running_sum;
  logic [7:0]             rx_sum;
  logic [1:0]             digits_seen;
  logic                   lead_taken;
  logic                   star_taken;
  logic                   digit_bad;
  logic                   tag_seen;

  out_item_t owed_verdicts[$];
  out_item_t oldest;
  int        fails;

  // Nibble value of a hex digit in either case, or -1 for any other byte.
  function automatic int nibble_of(input logic [7:0] c);
    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      return int'(c) - int'(CHAR_ZERO);
    end
    if (c >= CHAR_UPPR_A && c <= CHAR_UPPR_F) begin
      return int'(c) - int'(CHAR_UPPR_A) + 10;
    end
    if (c >= CHAR_LOWR_A && c <= CHAR_LOWR_F) begin
      return int'(c) - int'(CHAR_LOWR_A) + 10;
    end
    return -1;
  endfunction

  task automatic clear_line();
    prev_bytes  = '0;
    running_sum = '0;
    rx_sum      = '0;
    digits_seen = '0;
    lead_taken  = 1'b0;
    star_taken  = 1'b0;
    digit_bad   = 1'b0;
    tag_seen    = 1'b0;
  endtask

  // Advances the line state by one byte and owes a verdict on end of line.
  task automatic take_byte(input in_item_t item);
    logic [TagWidth-1:0] full;
    int                  nib;
    logic                bad_form;
    logic                sums_agree;
    out_item_t           verdict;

    // The tag may match at any byte, the window starting from zero.
    full = {prev_bytes, item.line_byte};
    if (full == tag_copy) begin
      tag_seen = 1'b1;
    end
    prev_bytes = full[WindowWidth-1:0];

    // The leading byte is dropped, then bytes are summed up to the first star
    // and the two bytes after it form the checksum; anything later is ignored.
    if (!lead_taken) begin
      lead_taken = 1'b1;
    end else if (!star_taken) begin
      if (item.line_byte == CHAR_STAR) begin
        star_taken = 1'b1;
      end else begin
        running_sum = running_sum ^ item.line_byte;
      end
    end else if (digits_seen < SUM_DIGITS) begin
      nib = nibble_of(item.line_byte);
      if (nib < 0) begin
        digit_bad = 1'b1;
        nib       = 0;
      end
      rx_sum      = {rx_sum[3:0], nib[3:0]};
      digits_seen = digits_seen + 2'd1;
    end

    if (item.end_of_line) begin
      bad_form   = !star_taken || (digits_seen < SUM_DIGITS) || digit_bad;
      sums_agree = !bad_form && (running_sum == rx_sum);
      verdict.sentence_ok  = tag_seen && sums_agree;
      verdict.tag_found    = tag_seen;
      verdict.sum_match    = sums_agree;
      verdict.format_error = bad_form;
      verdict.computed_sum = running_sum;
      verdict.received_sum = rx_sum;
      owed_verdicts.push_back(verdict);
      clear_line();
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      fails++;
    end
  endtask

  // Verdicts are checked before the byte of the same edge is predicted, so a
  // verdict can never be matched against an expectation that it overtook.
  always @(posedge clk) begin
    if (!rst_n) begin
      tag_copy = TAG_RESET;
      clear_line();
      owed_verdicts.delete();
      fails = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (owed_verdicts.size() == 0) begin
          $error("verdict transaction with none expected: %p", out_data);
          fails++;
        end else begin
          oldest = owed_verdicts.pop_front();
          check_field("sentence_ok", 8'(oldest.sentence_ok), 8'(out_data.sentence_ok));
          check_field("tag_found", 8'(oldest.tag_found), 8'(out_data.tag_found));
          check_field("sum_match", 8'(oldest.sum_match), 8'(out_data.sum_match));
          check_field("format_error", 8'(oldest.format_error),
                      8'(out_data.format_error));
          check_field("computed_sum", oldest.computed_sum, out_data.computed_sum);
          check_field("received_sum", oldest.received_sum, out_data.received_sum);
        end
      end
      if (in_valid && !in_stall) begin
        take_byte(in_data);
      end
      if (cfg_wr_en) begin
        tag_copy = cfg_wr_data;
      end
    end
    fail_count       <= fails;
    verdicts_pending <= owed_verdicts.size();
  end

endmodule

@@ tb/nmea_sentence_checker_top_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// NMEA sentence checker testbench
// Sends hand-picked lines and then mostly well-formed random sentences with
// broken ones mixed in, under several tag settings, with bursty byte traffic
// and a stalling verdict receiver. The verdict checker does the comparison.
// ----------------------------------------------------------------------------
module nmea_sentence_checker_top_test;
  import nsc_pkg::*;

  localparam int StallLimit  = 2000;
  localparam int PhaseBytes  = 150;
  localparam logic [7:0] CHAR_DOLLAR = 8'h24;
  localparam logic [7:0] CHAR_COMMA  = 8'h2C;
  localparam logic [7:0] CHAR_UPPR_G = 8'h47;

  logic                clk;
  logic                rst_n;
  logic                cfg_wr_en;
  logic [TagWidth-1:0] cfg_wr_data;
  logic                in_valid;
  logic                in_stall;
  in_item_t            in_data;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_item_t           out_data;

  int fail_count;
  int verdicts_pending;

  logic [7:0]          line_q[$];
  logic [TagWidth-1:0] cur_tag;
  int                  burst_left;
  int                  bytes_sent;
  int                  idle_cycles;
  int                  stall_mode;
  int                  stall_tick;

  nmea_sentence_checker_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

  nsc_verdict_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data        (out_data),
    .fail_count      (fail_count),
    .verdicts_pending(verdicts_pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // The receiver picks a new stall habit whenever stall_tick is a multiple of 64: none,
  // light, heavy or a regular on-off pattern that follows bit 2 of stall_tick.
  always @(negedge clk) begin
    if (stall_tick % 64 == 0) begin
      stall_mode = $urandom_range(0, 3);
    end
    stall_tick++;
    case (stall_mode)
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      3: out_stall <= stall_tick[2];
      default: out_stall <= 1'b0;
    endcase
  end

  // Ends the run when nothing has moved on either channel for too long.
  initial begin
    idle_cycles = 0;
    while (idle_cycles < StallLimit) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("FAIL");
    $finish;
  end

  function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
    if (n < 4'd10) begin
      return CHAR_ZERO + 8'(n);
    end
    return (lower ? CHAR_LOWR_A : CHAR_UPPR_A) + 8'(n) - 8'd10;
  endfunction

  // XOR of the bytes after the first one, up to the first star.
  function automatic logic [7:0] line_sum();
    logic [7:0] s;
    s = '0;
    for (int i = 1; i < line_q.size(); i++) begin
      if (line_q[i] == CHAR_STAR) begin
        break;
      end
      s = s ^ line_q[i];
    end
    return s;
  endfunction

  task automatic put_str(input string s);
    for (int i = 0; i < s.len(); i++) begin
      line_q.push_back(s[i]);
    end
  endtask

  // Case selection: 0 upper, 1 lower, 2 random for each digit.
  task automatic put_digits(input logic [7:0] v, input int case_sel);
    bit lower;
    lower = (case_sel == 2) ? bit'($urandom_range(0, 1)) : bit'(case_sel);
    line_q.push_back(hex_char(v[7:4], lower));
    lower = (case_sel == 2) ? bit'($urandom_range(0, 1)) : bit'(case_sel);
    line_q.push_back(hex_char(v[3:0], lower));
  endtask

  // Appends the current tag without its leading NUL bytes, since the window
  // is zero at the start of a line; an all-zero tag needs a single NUL.
  task automatic put_tag();
    logic [7:0] b;
    bit         started;
    started = 1'b0;
    for (int k = 5; k >= 0; k--) begin
      b = cur_tag[k*8 +: 8];
      if (b != 8'd0 || started) begin
        line_q.push_back(b);
        started = 1'b1;
      end
    end
    if (!started) begin
      line_q.push_back(8'd0);
    end
  endtask

  // Sender side: bursts of random length, random gaps between them.
  task automatic push_byte(input logic [7:0] b, input logic eol);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    @(negedge clk);
    in_data  <= '{line_byte: b, end_of_line: eol};
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    burst_left--;
    bytes_sent++;
  endtask

  task automatic send_line();
    foreach (line_q[i]) begin
      push_byte(line_q[i], i == line_q.size() - 1);
    end
    line_q.delete();
  endtask

  // Waits until every owed verdict is in and the pipeline has drained.
  task automatic drain(input int extra);
    @(negedge clk);
    in_valid <= 1'b0;
    while (verdicts_pending != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic write_tag(input logic [TagWidth-1:0] t);
    drain(4);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= t;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    cur_tag = t;
  endtask

  // Mostly well-formed sentences; the rest carry a wrong sum, a bad or
  // missing digit, or no star, with random noise bytes now and then.
  task automatic build_line();
    int         kind;
    int         idx;
    logic [7:0] b;
    logic [7:0] s;
    kind = $urandom_range(0, 9);
    if ($urandom_range(0, 2) != 0) begin
      put_tag();
    end else if ($urandom_range(0, 7) == 0) begin
      line_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      line_q.push_back(CHAR_DOLLAR);
      repeat ($urandom_range(0, 5)) line_q.push_back(8'($urandom_range(8'h41, 8'h5A)));
    end
    repeat ($urandom_range(0, 10)) begin
      if ($urandom_range(0, 7) == 0) begin
        b = 8'($urandom_range(0, 255));
      end else begin
        b = 8'($urandom_range(8'h20, 8'h7E));
        if (b == CHAR_STAR) begin
          b = CHAR_COMMA;
        end
      end
      line_q.push_back(b);
    end
    if ($urandom_range(0, 5) == 0) begin
      put_tag();
    end
    s = line_sum();
    case (kind)
      6: begin
        line_q.push_back(CHAR_STAR);
        put_digits(s ^ 8'($urandom_range(1, 255)), 2);
      end
      7: begin
        line_q.push_back(CHAR_STAR);
        put_digits(s, 2);
        idx = line_q.size() - 1 - $urandom_range(0, 1);
        b = 8'($urandom_range(0, 255));
        if ((b >= CHAR_ZERO && b <= CHAR_NINE) || (b >= CHAR_UPPR_A && b <= CHAR_UPPR_F) ||
            (b >= CHAR_LOWR_A && b <= CHAR_LOWR_F)) begin
          b = CHAR_UPPR_G;
        end
        line_q[idx] = b;
      end
      8: begin
        line_q.push_back(CHAR_STAR);
        if ($urandom_range(0, 1) == 1) begin
          line_q.push_back(hex_char(s[7:4], bit'($urandom_range(0, 1))));
        end
      end
      9: ;
      default: begin
        line_q.push_back(CHAR_STAR);
        put_digits(s, 2);
      end
    endcase
    if (kind <= 7 && $urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) line_q.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic random_phase(input logic [TagWidth-1:0] t);
    write_tag(t);
    bytes_sent = 0;
    while (bytes_sent < PhaseBytes) begin
      build_line();
      send_line();
    end
  endtask

  initial begin
    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    in_valid    = 1'b0;
    in_data     = '0;
    burst_left  = 0;
    stall_tick  = 0;
    stall_mode  = 0;
    cur_tag     = TAG_RESET;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // Hand-picked lines under the reset tag: a good sentence.
    put_str("$GPGGA");
    line_q.push_back(CHAR_STAR);
    put_digits(line_sum(), 0);
    send_line();
    // A single byte which is a star: only consumed, so a format error.
    put_str("*");
    send_line();
    // Star with no checksum digits after it.
    put_str("$A*");
    send_line();
    // No star at all.
    put_str("$B");
    send_line();
    // Star right after the first byte, then a non-hex digit and a later star.
    put_str("$*Z*");
    send_line();
    // Extreme byte values, lower-case checksum and a byte past the digits.
    line_q.push_back(8'h00);
    line_q.push_back(8'hFF);
    line_q.push_back(CHAR_STAR);
    put_digits(line_sum(), 1);
    line_q.push_back(CHAR_COMMA);
    send_line();

    // Random traffic under several tags, extremes and NUL-led tags included.
    random_phase(TAG_RESET);
    random_phase(48'h0000_0000_0000);
    random_phase(48'hFFFF_FFFF_FFFF);
    random_phase(48'h2447_5052_4D43);
    random_phase(48'h0000_0000_2447);
    random_phase(48'({$urandom, $urandom}));
    random_phase(TAG_RESET);

    drain(8);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/nsc_pkg.sv
design/nsc_line_tracker.sv
design/nmea_sentence_checker_top.sv
tb/nsc_verdict_checker.sv
tb/nmea_sentence_checker_top_test.sv
